// ----- rtl/rmf_pkg.sv -----
// Shared types for the running median filter: the status link passed between sorted cells.
`default_nettype none

package rmf_pkg;

	// Status that one cell hands to the cell below it in the sorted row; the cell above also reads its ge bit.
	typedef struct packed {
		logic ge;   // The held sample is greater than or equal to the incoming sample.
		logic gone; // The evicted sample sits in this cell or in one above it.
	} rmf_link_t;

endpackage

`default_nettype wire

// ----- rtl/running_median_filter.sv -----
// Running median filter top level: sorted cell row, fill counter, median select and output register.
// Pipeline: an accepted sample updates the cell row and enters the select stage; its median is then
// registered into the output register, from which the result beat is taken (select stage, output register).
// Throughput: one sample per cycle unless a stalled consumer holds the select stage; the sorted cell row
// inserts and evicts in the cycle of acceptance, in one combined step, which sets the throughput.
// Reset: arst_n clears the fill count, the pipeline valids and fills every cell with the reserved code.
// No clearing pass is needed after reset; the block accepts samples in the first cycle.
`default_nettype none

module running_median_filter #(
	parameter int WINDOW      = 9,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed      [SAMPLE_BITS-1:0] median_value
);
	import rmf_pkg::*;

	localparam int AGE_BITS  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
	localparam int IDX_BITS  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
	localparam int FILL_BITS = $clog2(WINDOW + 1);
	localparam logic signed [SAMPLE_BITS-1:0] SENTINEL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(WINDOW);

	// The cells hold the window in descending order. Empty cells hold the reserved most
	// negative code, which no clamped sample can equal, so they always sort to the bottom.
	logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW];
	logic        [AGE_BITS-1:0]    cell_age   [WINDOW];
	rmf_link_t                     cell_link  [WINDOW];

	logic                          accept;
	logic signed [SAMPLE_BITS-1:0] new_value;
	logic [FILL_BITS-1:0]          fill_q;
	logic                          full;
	logic [FILL_BITS-1:0]          held_next;
	logic [IDX_BITS-1:0]           median_idx;

	logic                          valid_s1;
	logic [IDX_BITS-1:0]           idx_s1;
	logic                          adv_s1;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic signed [SAMPLE_BITS-1:0] selected;

	// The input beat is taken whenever the select stage is empty or moves on in this cycle.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// The reserved code is raised by one so that it never collides with an empty cell.
	assign new_value = (sample == SENTINEL) ? SENTINEL + SAMPLE_BITS'(1) : sample;

	// Once the window is full, the cell whose age reaches WINDOW-1 is evicted.
	assign full = (fill_q == FILL_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && !full) begin
			fill_q <= fill_q + FILL_BITS'(1);
		end
	end

	// The result is the ceil(k/2)-th largest of k held samples, which is row index (k-1)/2.
	assign held_next  = full ? FILL_MAX : fill_q + FILL_BITS'(1);
	assign median_idx = IDX_BITS'((held_next - FILL_BITS'(1)) >> 1);

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_cell
			logic signed [SAMPLE_BITS-1:0] up_value;
			logic        [AGE_BITS-1:0]    up_age;
			rmf_link_t                     up_link;
			logic signed [SAMPLE_BITS-1:0] down_value;
			logic        [AGE_BITS-1:0]    down_age;
			logic                          down_ge;

			// The top cell sees a virtual neighbor that outranks every sample and is never
			// evicted; the bottom cell sees an empty neighbor.
			if (gi == 0) begin : g_top
				assign up_value     = SENTINEL;
				assign up_age       = '0;
				assign up_link.ge   = 1'b1;
				assign up_link.gone = 1'b0;
			end else begin : g_mid
				assign up_value = cell_value[gi-1];
				assign up_age   = cell_age[gi-1];
				assign up_link  = cell_link[gi-1];
			end

			if (gi == WINDOW - 1) begin : g_bottom
				assign down_value = SENTINEL;
				assign down_age   = '0;
				assign down_ge    = 1'b0;
			end else begin : g_inner
				assign down_value = cell_value[gi+1];
				assign down_age   = cell_age[gi+1];
				assign down_ge    = cell_link[gi+1].ge;
			end

			rmf_cell #(
				.SAMPLE_BITS (SAMPLE_BITS),
				.AGE_BITS    (AGE_BITS),
				.WINDOW      (WINDOW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.load       (accept),
				.full       (full),
				.new_value  (new_value),
				.up_value   (up_value),
				.up_age     (up_age),
				.up_link    (up_link),
				.down_value (down_value),
				.down_age   (down_age),
				.down_ge    (down_ge),
				.value      (cell_value[gi]),
				.age        (cell_age[gi]),
				.link       (cell_link[gi])
			);
		end
	endgenerate

	// Select stage: the row has been updated by the accepted beat, and it stays put while
	// this stage holds, because no further beat is taken until the stage moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= median_idx;
		end
	end

	always_comb begin
		selected = cell_value[0];
		for (int i = 0; i < WINDOW; i++) begin
			if (idx_s1 == IDX_BITS'(i)) begin
				selected = cell_value[i];
			end
		end
	end

	// Output register: keeps a finished median while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			median_q <= selected;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = median_q;

	// A delivered median is always a real sample, never the empty-cell code.
	a_no_sentinel_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (median_q != SENTINEL))
		else $error("median output carries the empty-cell code");

	// The fill count saturates at the window length.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count beyond window length");

	// After the first sample the top cell holds a real sample.
	a_top_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> (cell_value[0] != SENTINEL))
		else $error("top cell empty while samples are held");

	// The row stays in descending order after every update.
	generate
		for (gi = 0; gi < WINDOW - 1; gi++) begin : g_order_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				cell_value[gi] >= cell_value[gi+1])
				else $error("sorted cell row out of order");
		end
	endgenerate

endmodule

`default_nettype wire

// ----- rtl/rmf_cell.sv -----
// One cell of the sorted sample row: holds a sample and its age and shifts with its neighbors.
`default_nettype none

module rmf_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_BITS    = 4,
	parameter int WINDOW      = 9
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic                          full,
	input  wire logic signed [SAMPLE_BITS-1:0] new_value,
	input  wire logic signed [SAMPLE_BITS-1:0] up_value,
	input  wire logic        [AGE_BITS-1:0]    up_age,
	input  wire rmf_pkg::rmf_link_t            up_link,
	input  wire logic signed [SAMPLE_BITS-1:0] down_value,
	input  wire logic        [AGE_BITS-1:0]    down_age,
	input  wire logic                          down_ge,
	output logic signed      [SAMPLE_BITS-1:0] value,
	output logic             [AGE_BITS-1:0]    age,
	output rmf_pkg::rmf_link_t                 link
);
	import rmf_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] SENTINEL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [AGE_BITS-1:0] OLDEST_AGE = AGE_BITS'(WINDOW - 1);

	logic signed [SAMPLE_BITS-1:0] value_q;
	logic        [AGE_BITS-1:0]    age_q;
	logic                          evict;
	logic                          ge;
	logic signed [SAMPLE_BITS-1:0] w_value;
	logic        [AGE_BITS-1:0]    w_age;
	logic                          w_ge;
	logic signed [SAMPLE_BITS-1:0] wp_value;
	logic        [AGE_BITS-1:0]    wp_age;
	logic                          wp_ge;
	logic signed [SAMPLE_BITS-1:0] value_d;
	logic        [AGE_BITS-1:0]    age_d;

	assign evict = full && (age_q == OLDEST_AGE);
	assign ge    = (value_q >= new_value);

	// Contents of this slot and of the slot above once the evicted sample is squeezed out.
	assign w_value  = link.gone ? down_value : value_q;
	assign w_age    = link.gone ? down_age : age_q;
	assign w_ge     = link.gone ? down_ge : ge;
	assign wp_value = up_link.gone ? value_q : up_value;
	assign wp_age   = up_link.gone ? age_q : up_age;
	assign wp_ge    = up_link.gone ? ge : up_link.ge;

	always_comb begin
		if (w_ge) begin
			value_d = w_value;
			age_d   = w_age + AGE_BITS'(1);
		end else if (wp_ge) begin
			value_d = new_value;
			age_d   = '0;
		end else begin
			value_d = wp_value;
			age_d   = wp_age + AGE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= SENTINEL;
			age_q   <= '0;
		end else if (load) begin
			value_q <= value_d;
			age_q   <= age_d;
		end
	end

	assign value     = value_q;
	assign age       = age_q;
	assign link.ge   = ge;
	assign link.gone = up_link.gone | evict;

endmodule

`default_nettype wire
